// File: rtl/drex_pkg.sv
package drex_pkg;

  localparam int unsigned VALUE_BITS = 14;
  localparam int unsigned REF_BITS   = 8;
  localparam int unsigned MAPPED_W   = 16;

  // A product of a sample and a grey level, and the offset numerator, fit in PROD_W bits.
  localparam int unsigned PROD_W    = VALUE_BITS + REF_BITS + 1;
  localparam int unsigned MAG_W     = PROD_W - 1;
  localparam int unsigned DIV_CNT_W = $clog2(MAG_W);

  localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
  localparam logic [REF_BITS-1:0] REF_MIN = '0;

  typedef enum logic [1:0] {
    CMD_MEASURE = 2'd0,
    CMD_MAP     = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_e;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] quot;
  } div_res_t;

endpackage

// File: rtl/drex_if.sv
interface drex_in_if;
  import drex_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [1:0]                   cmd;
  logic [REF_BITS-1:0]          ref_pixel;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output cmd, output ref_pixel, output value, input ready);
  modport sink (input valid, input cmd, input ref_pixel, input value, output ready);
endinterface

interface drex_out_if;
  import drex_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [MAPPED_W-1:0] mapped;
  logic                       range_error;

  modport source (output valid, output mapped, output range_error, input ready);
  modport sink (input valid, input mapped, input range_error, output ready);
endinterface

// File: rtl/drex_div.sv
module drex_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [drex_pkg::MAG_W-1:0]          dividend_i,
  input  logic [drex_pkg::VALUE_BITS-1:0]     divisor_i,
  output drex_pkg::div_res_t                  res_o
);
  import drex_pkg::*;

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [MAG_W-1:0]       quo_q, quo_d;
  logic [VALUE_BITS-1:0]  rem_q, rem_d;
  logic [VALUE_BITS-1:0]  den_q, den_d;
  logic [VALUE_BITS:0]    trial;
  logic [VALUE_BITS:0]    diff;
  logic                   last_step;

  assign trial     = {rem_q, quo_q[MAG_W-1]};
  assign diff      = trial - {1'b0, den_q};
  assign last_step = (cnt_q == DIV_CNT_W'(MAG_W - 1));

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[VALUE_BITS]) begin
        rem_d = diff[VALUE_BITS-1:0];
        quo_d = {quo_q[MAG_W-2:0], 1'b1};
      end else begin
        rem_d = trial[VALUE_BITS-1:0];
        quo_d = {quo_q[MAG_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (last_step) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = quo_q;

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && last_step && !start_i |=> done_q && !busy_q)
    else $error("divider missed its last step");
`endif

endmodule

// File: rtl/dynamic_range_expansion_top.sv
// Channel  Direction  Fields
// in_i     sink       cmd[1:0], ref_pixel[7:0], value[VALUE_BITS-1:0] signed
// out_o    source     mapped[15:0] signed, range_error
//
// A measure or clear word updates the statistics; a code of three is dropped.
// A map word with a valid range runs through the states MUL, NUM, GDIV and ODIV, using
// the shared radix-2 divider that computes first the gain and then the offset.
// A map word with no measurement or a zero value range gives a range error.
// Reset is asynchronous and active low and restores the statistics at once.
// The result waits in an output register, so measure and clear words are taken while it stalls.
module dynamic_range_expansion_top (
  input  logic clk_i,
  input  logic rst_ni,
  drex_in_if.sink    in_i,
  drex_out_if.source out_o
);
  import drex_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_NUM  = 5'b00100,
    S_GDIV = 5'b01000,
    S_ODIV = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   done_pend_q, done_pend_d;

  logic [REF_BITS-1:0]          ref_low_q, ref_low_d;
  logic [REF_BITS-1:0]          ref_high_q, ref_high_d;
  logic signed [VALUE_BITS-1:0] val_low_q, val_low_d;
  logic signed [VALUE_BITS-1:0] val_high_q, val_high_d;
  logic                         measured_q, measured_d;

  logic signed [VALUE_BITS-1:0] v_q, v_d;
  logic [VALUE_BITS-1:0]        vr_q, vr_d;
  logic signed [PROD_W-1:0]     prod_q, prod_d;
  logic signed [PROD_W-1:0]     num_q, num_d;
  logic [REF_BITS-1:0]          gain_q, gain_d;
  logic                         neg_q, neg_d;
  logic signed [MAPPED_W-1:0]   res_mapped_q, res_mapped_d;
  logic                         res_err_q, res_err_d;

  logic                         out_valid_q, out_valid_d;
  logic signed [MAPPED_W-1:0]   out_mapped_q, out_mapped_d;
  logic                         out_err_q, out_err_d;

  logic                         in_fire;
  logic                         out_free;
  logic signed [VALUE_BITS:0]   vdiff;
  logic                         div_start;
  logic [MAG_W-1:0]             div_dividend;
  div_res_t                     div_res;
  logic [PROD_W-1:0]            num_abs;
  logic signed [PROD_W-1:0]     gv;
  logic [MAPPED_W-1:0]          off16;

  assign in_i.ready = (state_q == S_IDLE) && !done_pend_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign vdiff      = {val_high_q[VALUE_BITS-1], val_high_q} - {val_low_q[VALUE_BITS-1], val_low_q};
  assign num_abs    = num_q[PROD_W-1] ? -num_q : num_q;
  assign gv         = $signed({1'b0, gain_q}) * v_q;
  assign off16      = neg_q ? -div_res.quot[MAPPED_W-1:0] : div_res.quot[MAPPED_W-1:0];

  assign div_start    = (state_q == S_MUL) || ((state_q == S_GDIV) && div_res.done);
  assign div_dividend = (state_q == S_MUL) ? {{(MAG_W-REF_BITS){1'b0}}, ref_high_q - ref_low_q}
                                           : num_abs[MAG_W-1:0];

  drex_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (vr_q),
    .res_o      (div_res)
  );

  always_comb begin
    state_d      = state_q;
    done_pend_d  = done_pend_q;
    ref_low_d    = ref_low_q;
    ref_high_d   = ref_high_q;
    val_low_d    = val_low_q;
    val_high_d   = val_high_q;
    measured_d   = measured_q;
    v_d          = v_q;
    vr_d         = vr_q;
    prod_d       = prod_q;
    num_d        = num_q;
    gain_d       = gain_q;
    neg_d        = neg_q;
    res_mapped_d = res_mapped_q;
    res_err_d    = res_err_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_mapped_d = out_mapped_q;
    out_err_d    = out_err_q;

    case (state_q)
      S_IDLE: begin
        if (done_pend_q && out_free) begin
          done_pend_d  = 1'b0;
          out_valid_d  = 1'b1;
          out_mapped_d = res_mapped_q;
          out_err_d    = res_err_q;
        end else if (in_fire) begin
          case (in_i.cmd)
            CMD_MEASURE: begin
              if (in_i.ref_pixel < ref_low_q) ref_low_d = in_i.ref_pixel;
              if (in_i.ref_pixel > ref_high_q) ref_high_d = in_i.ref_pixel;
              if (in_i.value < val_low_q) val_low_d = in_i.value;
              if (in_i.value > val_high_q) val_high_d = in_i.value;
              measured_d = 1'b1;
            end
            CMD_CLEAR: begin
              ref_low_d  = REF_MAX;
              ref_high_d = REF_MIN;
              val_low_d  = VAL_MAX;
              val_high_d = VAL_MIN;
              measured_d = 1'b0;
            end
            CMD_MAP: begin
              v_d  = in_i.value;
              vr_d = vdiff[VALUE_BITS-1:0];
              if (!measured_q || (val_high_q <= val_low_q)) begin
                res_mapped_d = '0;
                res_err_d    = 1'b1;
                done_pend_d  = 1'b1;
              end else begin
                state_d = S_MUL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_MUL: begin
        prod_d  = $signed(val_high_q) * $signed({1'b0, ref_low_q});
        state_d = S_NUM;
      end
      S_NUM: begin
        num_d   = prod_q - $signed({1'b0, ref_high_q}) * val_low_q;
        state_d = S_GDIV;
      end
      S_GDIV: begin
        if (div_res.done) begin
          gain_d  = div_res.quot[REF_BITS-1:0];
          neg_d   = num_q[PROD_W-1];
          state_d = S_ODIV;
        end
      end
      S_ODIV: begin
        if (div_res.done) begin
          res_mapped_d = gv[MAPPED_W-1:0] + off16;
          res_err_d    = 1'b0;
          done_pend_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      done_pend_q <= 1'b0;
      ref_low_q   <= REF_MAX;
      ref_high_q  <= REF_MIN;
      val_low_q   <= VAL_MAX;
      val_high_q  <= VAL_MIN;
      measured_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      done_pend_q <= done_pend_d;
      ref_low_q   <= ref_low_d;
      ref_high_q  <= ref_high_d;
      val_low_q   <= val_low_d;
      val_high_q  <= val_high_d;
      measured_q  <= measured_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q          <= v_d;
    vr_q         <= vr_d;
    prod_q       <= prod_d;
    num_q        <= num_d;
    gain_q       <= gain_d;
    neg_q        <= neg_d;
    res_mapped_q <= res_mapped_d;
    res_err_q    <= res_err_d;
    out_mapped_q <= out_mapped_d;
    out_err_q    <= out_err_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.mapped      = out_mapped_q;
  assign out_o.range_error = out_err_q;

`ifndef ASSERT_OFF
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_err_q |-> out_mapped_q == '0)
    else $error("range error word carries a nonzero value");
  a_ref_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    measured_q |-> ref_low_q <= ref_high_q)
    else $error("reference minimum above maximum");
  a_val_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    measured_q |-> val_low_q <= val_high_q)
    else $error("sample minimum above maximum");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_i.cmd == CMD_CLEAR) |=> !measured_q)
    else $error("clear word did not reset the statistics");
`endif

endmodule
